FILE: src/ssbb_pkg.sv
// shared types, constants and the glide function of the stereo slot blur buffer
package ssbb_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int ACC_BITS = 32;
   localparam int ACC_FRAC = ACC_BITS - SAMPLE_BITS;
   localparam int GAIN_BITS = 17;
   localparam int GAIN_FRAC = 14;
   localparam int DECAY_FRAC = 31;
   localparam int SMOOTH_BITS = 32;
   localparam int LEN_BITS = 16;
   localparam int DECAY_BITS = 16;
   localparam int GLIDE_BITS = 9;
   localparam int GLIDE_FRAC = 15;
   localparam int LIM_BITS = 17;
   localparam int MAX_LEN_DEFAULT = 65536;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAY_TARGET = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GLIDE_COEF = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME_GAIN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREEZE = 3'd4;

   localparam logic [LEN_BITS-1:0] TARGET_LENGTH_RESET = 16'd2756;
   localparam logic [DECAY_BITS-1:0] DECAY_TARGET_RESET = 16'd1311;
   localparam logic [GLIDE_BITS-1:0] GLIDE_COEF_RESET = 9'd82;
   localparam logic [GAIN_BITS-1:0] VOLUME_GAIN_RESET = 17'd32113;
   localparam logic [DECAY_BITS-1:0] DECAY_ONE = 16'd32768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLEND,
      ST_WRITE,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]   target_length;
      logic [DECAY_BITS-1:0] decay_target;
      logic [GLIDE_BITS-1:0] glide_coef;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic blend;
      logic write;
      logic scale;
      logic entry_valid;
      logic freeze;
   } lane_ctrl_type;

   // one glide step, the step magnitude truncated toward zero
   function automatic logic [SMOOTH_BITS-1:0] glide(
      input logic [SMOOTH_BITS-1:0] cur,
      input logic [SMOOTH_BITS-1:0] tgt,
      input logic [GLIDE_BITS-1:0]  coef
   );
      logic                                  up;
      logic [SMOOTH_BITS-1:0]                diff;
      logic [SMOOTH_BITS+GLIDE_BITS-1:0]     prod;
      logic [SMOOTH_BITS-1:0]                step;
      up = (tgt >= cur);
      diff = up ? (tgt - cur) : (cur - tgt);
      prod = diff * coef;
      step = SMOOTH_BITS'(prod >> GLIDE_FRAC);
      glide = up ? (cur + step) : (cur - step);
   endfunction

endpackage

FILE: src/stereo_slot_blur_buffer.sv
// top level of the stereo slot blur buffer: registers, lanes and output stage
//
// Takes one stereo pair per transaction and returns one blurred pair. Each pair
// occupies the block through accept, blend multiply, slot write-back, gain
// multiply and output load, steps set by the read-modify-write of the slot memory
// followed by two multiplies in series. req_ready is high only while no
// pair is in flight, but a finished result waits in the output register, so the
// next pair is taken while it is still pending. The slot memories need no
// clearing pass after reset: a fill mark tracks how far slots have been visited,
// and any slot past it reads as zero. Configuration is written through the csr_
// channel (always ready); writes to indexes beyond the register list are dropped.
module stereo_slot_blur_buffer #(
   parameter int MAX_LEN = ssbb_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [ssbb_pkg::SAMPLE_BITS-1:0]     req_left_in,
   input  logic signed [ssbb_pkg::SAMPLE_BITS-1:0]     req_right_in,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [ssbb_pkg::SAMPLE_BITS-1:0]     rsp_left_out,
   output logic signed [ssbb_pkg::SAMPLE_BITS-1:0]     rsp_right_out,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [ssbb_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [ssbb_pkg::CSR_DATA_BITS-1:0]          csr_data
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int SB = ssbb_pkg::SAMPLE_BITS;

   logic [ssbb_pkg::LEN_BITS-1:0]   target_length_ff;
   logic [ssbb_pkg::DECAY_BITS-1:0] decay_target_ff;
   logic [ssbb_pkg::GLIDE_BITS-1:0] glide_coef_ff;
   logic [ssbb_pkg::GAIN_BITS-1:0]  volume_gain_ff;
   logic                            freeze_ff;

   ssbb_pkg::cfg_type       cfg;
   ssbb_pkg::lane_ctrl_type lane_ctrl;
   logic [AW-1:0]           addr;
   logic [ssbb_pkg::SMOOTH_BITS-1:0] decay;
   logic                    out_free;
   logic                    load_out;
   logic signed [SB-1:0]    left_res;
   logic signed [SB-1:0]    right_res;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]    left_out_ff;
   logic signed [SB-1:0]    right_out_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_length_ff <= ssbb_pkg::TARGET_LENGTH_RESET;
         decay_target_ff <= ssbb_pkg::DECAY_TARGET_RESET;
         glide_coef_ff <= ssbb_pkg::GLIDE_COEF_RESET;
         volume_gain_ff <= ssbb_pkg::VOLUME_GAIN_RESET;
         freeze_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ssbb_pkg::CSR_TARGET_LENGTH:
               target_length_ff <= csr_data[ssbb_pkg::LEN_BITS-1:0];
            ssbb_pkg::CSR_DECAY_TARGET:
               decay_target_ff <= csr_data[ssbb_pkg::DECAY_BITS-1:0];
            ssbb_pkg::CSR_GLIDE_COEF:
               glide_coef_ff <= csr_data[ssbb_pkg::GLIDE_BITS-1:0];
            ssbb_pkg::CSR_VOLUME_GAIN:
               volume_gain_ff <= csr_data[ssbb_pkg::GAIN_BITS-1:0];
            ssbb_pkg::CSR_FREEZE:
               freeze_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.target_length = target_length_ff;
      cfg.decay_target = decay_target_ff;
      cfg.glide_coef = glide_coef_ff;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   ssbb_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .cfg       (cfg),
      .freeze    (freeze_ff),
      .lane_ctrl (lane_ctrl),
      .addr      (addr),
      .decay     (decay),
      .load_out  (load_out)
   );

   ssbb_lane #(
      .MAX_LEN (MAX_LEN)
   ) u_lane_left (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .addr       (addr),
      .decay      (decay),
      .gain       (volume_gain_ff),
      .sample_in  (req_left_in),
      .sample_out (left_res)
   );

   ssbb_lane #(
      .MAX_LEN (MAX_LEN)
   ) u_lane_right (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .addr       (addr),
      .decay      (decay),
      .gain       (volume_gain_ff),
      .sample_in  (req_right_in),
      .sample_out (right_res)
   );

   // merge both lanes into one output transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_out) begin
         left_out_ff <= left_res;
         right_out_ff <= right_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_out = left_out_ff;
   assign rsp_right_out = right_out_ff;

`ifndef SYNTH
   // one pair in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a pair is in flight");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");
`endif

endmodule

FILE: src/ssbb_ram.sv
// generic single-write, registered-read memory
module ssbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ssbb_lane.sv
// one channel lane: slot memory, blend toward held sample, gain and saturation
module ssbb_lane #(
   parameter int MAX_LEN = ssbb_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                     clock,
   input  ssbb_pkg::lane_ctrl_type                  ctrl,
   input  logic [$clog2(MAX_LEN)-1:0]               addr,
   input  logic [ssbb_pkg::SMOOTH_BITS-1:0]         decay,
   input  logic [ssbb_pkg::GAIN_BITS-1:0]           gain,
   input  logic signed [ssbb_pkg::SAMPLE_BITS-1:0]  sample_in,
   output logic signed [ssbb_pkg::SAMPLE_BITS-1:0]  sample_out
);

   localparam int SB = ssbb_pkg::SAMPLE_BITS;
   localparam int AB = ssbb_pkg::ACC_BITS;
   localparam int AF = ssbb_pkg::ACC_FRAC;
   localparam int RAM_W = SB + AB;
   localparam int DIFF_W = AB + 1;
   localparam int BPROD_W = DIFF_W + ssbb_pkg::SMOOTH_BITS;
   localparam int SUM_W = AB + 2;
   localparam int GPROD_W = AB + ssbb_pkg::GAIN_BITS + 1;
   localparam int SHIFT = ssbb_pkg::GAIN_FRAC + AF;
   localparam int Q_W = GPROD_W - SHIFT;
   localparam logic [Q_W-1:0] POS_MAX = Q_W'((64'd1 << (SB - 1)) - 64'd1);
   localparam logic [Q_W-1:0] NEG_MAX = Q_W'(64'd1 << (SB - 1));

   logic [SB-1:0]        sample_ff;
   logic [RAM_W-1:0]     rd_data;
   logic [RAM_W-1:0]     wr_data;

   logic [SB-1:0]        held_cur;
   logic [AB-1:0]        acc_cur;
   logic [AB-1:0]        held_scaled;
   logic [DIFF_W-1:0]    diff;
   logic [DIFF_W-1:0]    diff_mag;

   logic [SB-1:0]        held_ff;
   logic [AB-1:0]        acc_ff;
   logic                 neg_ff;
   logic [BPROD_W-1:0]   bprod_ff;

   logic [SUM_W-1:0]     step;
   logic [SUM_W-1:0]     acc_sum;
   logic [AB-1:0]        acc_new;
   logic [AB-1:0]        acc_new_ff;

   logic signed [GPROD_W-1:0] gprod_ff;
   logic [GPROD_W-1:0]        gmag;
   logic [Q_W-1:0]            qmag;

   ssbb_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_LEN)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ctrl.write),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (ctrl.capture),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // slots past the fill mark read as zero
   always_comb begin
      if (ctrl.freeze) begin
         held_cur = ctrl.entry_valid ? rd_data[RAM_W-1:AB] : '0;
      end else begin
         held_cur = sample_ff;
      end
      acc_cur = ctrl.entry_valid ? rd_data[AB-1:0] : '0;
      held_scaled = {held_cur, AF'(0)};
      diff = {held_scaled[AB-1], held_scaled} - {acc_cur[AB-1], acc_cur};
      diff_mag = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
   end

   always_comb begin
      step = SUM_W'(bprod_ff >> ssbb_pkg::DECAY_FRAC);
      if (neg_ff) begin
         acc_sum = {{2{acc_ff[AB-1]}}, acc_ff} - step;
      end else begin
         acc_sum = {{2{acc_ff[AB-1]}}, acc_ff} + step;
      end
      acc_new = acc_sum[AB-1:0];
      wr_data = {held_ff, acc_new};
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         sample_ff <= sample_in;
      end
      if (ctrl.blend) begin
         held_ff <= held_cur;
         acc_ff <= acc_cur;
         neg_ff <= diff[DIFF_W-1];
         bprod_ff <= BPROD_W'(diff_mag * decay);
      end
      if (ctrl.write) begin
         acc_new_ff <= acc_new;
      end
      if (ctrl.scale) begin
         gprod_ff <= GPROD_W'($signed(acc_new_ff) * $signed({1'b0, gain}));
      end
   end

   // truncate toward zero, then saturate
   always_comb begin
      gmag = gprod_ff[GPROD_W-1] ? (GPROD_W'(0) - gprod_ff) : gprod_ff;
      qmag = gmag[GPROD_W-1:SHIFT];
      if (gprod_ff[GPROD_W-1]) begin
         if (qmag > NEG_MAX) begin
            sample_out = SB'(Q_W'(0) - NEG_MAX);
         end else begin
            sample_out = SB'(Q_W'(0) - qmag);
         end
      end else begin
         if (qmag > POS_MAX) begin
            sample_out = SB'(POS_MAX);
         end else begin
            sample_out = SB'(qmag);
         end
      end
   end

endmodule

FILE: src/ssbb_ctrl.sv
// sequencer: transaction steps, length and decay smoothing, position and fill mark
module ssbb_ctrl #(
   parameter int MAX_LEN = ssbb_pkg::MAX_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              out_free,
   input  ssbb_pkg::cfg_type                 cfg,
   input  logic                              freeze,
   output ssbb_pkg::lane_ctrl_type           lane_ctrl,
   output logic [$clog2(MAX_LEN)-1:0]        addr,
   output logic [ssbb_pkg::SMOOTH_BITS-1:0]  decay,
   output logic                              load_out
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = ssbb_pkg::LIM_BITS;
   localparam int SW = ssbb_pkg::SMOOTH_BITS;
   localparam logic [LW-1:0] MAX_LIM = LW'(MAX_LEN);

   ssbb_pkg::state_type st_ff, st_in;

   logic [AW-1:0] pos_ff, pos_in;
   logic [AW:0]   fill_ff, fill_in;
   logic          ev_ff, ev_in;
   logic [SW-1:0] slen_ff, slen_in;
   logic [SW-1:0] sdec_ff, sdec_in;

   logic                         accept;
   logic [ssbb_pkg::DECAY_BITS-1:0] dec_tgt;
   logic [LW-1:0]                pos_inc;
   logic [LW-1:0]                len;
   logic [LW-1:0]                lim;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ssbb_pkg::ST_IDLE: begin
            if (req_valid) st_in = ssbb_pkg::ST_BLEND;
         end
         ssbb_pkg::ST_BLEND: st_in = ssbb_pkg::ST_WRITE;
         ssbb_pkg::ST_WRITE: st_in = ssbb_pkg::ST_SCALE;
         ssbb_pkg::ST_SCALE: st_in = ssbb_pkg::ST_DONE;
         ssbb_pkg::ST_DONE: begin
            if (out_free) st_in = ssbb_pkg::ST_IDLE;
         end
         default: st_in = ssbb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (st_ff == ssbb_pkg::ST_IDLE);
      accept = req_ready && req_valid;
      lane_ctrl.capture = accept;
      lane_ctrl.blend = (st_ff == ssbb_pkg::ST_BLEND);
      lane_ctrl.write = (st_ff == ssbb_pkg::ST_WRITE);
      lane_ctrl.scale = (st_ff == ssbb_pkg::ST_SCALE);
      lane_ctrl.entry_valid = ev_ff;
      lane_ctrl.freeze = freeze;
      load_out = (st_ff == ssbb_pkg::ST_DONE) && out_free;
      addr = pos_ff;
      decay = sdec_ff;
   end

   always_comb begin
      dec_tgt = (cfg.decay_target > ssbb_pkg::DECAY_ONE) ? ssbb_pkg::DECAY_ONE
                                                         : cfg.decay_target;
      slen_in = slen_ff;
      sdec_in = sdec_ff;
      ev_in = ev_ff;
      if (accept) begin
         slen_in = ssbb_pkg::glide(slen_ff, {cfg.target_length, 16'd0}, cfg.glide_coef);
         sdec_in = ssbb_pkg::glide(sdec_ff, {dec_tgt, 16'd0}, cfg.glide_coef);
         ev_in = ({1'b0, pos_ff} < fill_ff);
      end

      // wrap at the integer part of the smoothed length, capped at the depth
      pos_inc = LW'(pos_ff) + LW'(1);
      len = LW'(slen_ff[SW-1:SW-ssbb_pkg::LEN_BITS]);
      lim = (len < MAX_LIM) ? len : MAX_LIM;
      pos_in = pos_ff;
      fill_in = fill_ff;
      if (lane_ctrl.write) begin
         pos_in = (pos_inc >= lim) ? '0 : pos_inc[AW-1:0];
         if (!ev_ff) fill_in = fill_ff + (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ssbb_pkg::ST_IDLE;
         pos_ff <= '0;
         fill_ff <= '0;
         ev_ff <= 1'b0;
         slen_ff <= '0;
         sdec_ff <= '0;
      end else begin
         st_ff <= st_in;
         pos_ff <= pos_in;
         fill_ff <= fill_in;
         ev_ff <= ev_in;
         slen_ff <= slen_in;
         sdec_ff <= sdec_in;
      end
   end

`ifndef SYNTH
   // slots are visited in order from zero, so the position never passes the fill mark
   a_pos_within_fill: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} <= fill_ff)
      else $error("position beyond fill mark");

   a_fill_within_depth: assert property (@(posedge clock) disable iff (reset)
      LW'(fill_ff) <= MAX_LIM)
      else $error("fill mark beyond memory depth");
`endif

endmodule

FILE: verif/tb_stereo_slot_blur_buffer.sv
// self-checking testbench of the stereo slot blur buffer with its own blur predictor
`timescale 1ns / 1ps

module tb_stereo_slot_blur_buffer;

   localparam int SB = ssbb_pkg::SAMPLE_BITS;
   localparam int AB = ssbb_pkg::ACC_BITS;
   localparam int SMB = ssbb_pkg::SMOOTH_BITS;
   localparam int LB = ssbb_pkg::LEN_BITS;
   localparam int DB = ssbb_pkg::DECAY_BITS;
   localparam int GLB = ssbb_pkg::GLIDE_BITS;
   localparam int GNB = ssbb_pkg::GAIN_BITS;
   localparam int CIB = ssbb_pkg::CSR_INDEX_BITS;
   localparam int CDB = ssbb_pkg::CSR_DATA_BITS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 10;
   localparam int MAX_REPORTS = 100;
   localparam int STORE_DEPTH = ssbb_pkg::MAX_LEN_DEFAULT;
   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SB-1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   typedef struct packed {
      logic signed [SB-1:0] left_out;
      logic signed [SB-1:0] right_out;
   } blurred_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SB-1:0] req_left_in = '0;
   logic signed [SB-1:0] req_right_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SB-1:0] rsp_left_out;
   logic signed [SB-1:0] rsp_right_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CIB-1:0] csr_index = '0;
   logic [CDB-1:0] csr_data = '0;

   stereo_slot_blur_buffer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #1 clock = ~clock;

   // shadow registers and blur state
   logic [LB-1:0]    cfg_length;
   logic [DB-1:0]    cfg_decay;
   logic [GLB-1:0]   cfg_glide;
   logic [GNB-1:0]   cfg_gain;
   logic             cfg_freeze;
   logic [LB-1:0]    slot_pos;
   logic [SMB-1:0]   glided_len;
   logic [SMB-1:0]   glided_decay;
   logic signed [SB-1:0] held_left [STORE_DEPTH];
   logic signed [SB-1:0] held_right [STORE_DEPTH];
   logic signed [AB-1:0] sum_left [STORE_DEPTH];
   logic signed [AB-1:0] sum_right [STORE_DEPTH];

   blurred_pair_type expected_pairs[$];
   int fail_count = 0;
   int cycle_count = 0;
   int tx_gap_max = 0;
   int burst_left = 0;
   int rx_stall_pct = 0;
   int rx_run = 0;
   int rx_hold = 0;

   function automatic logic [SMB-1:0] glide_toward(
      input logic [SMB-1:0] cur,
      input logic [63:0]    goal,
      input logic [GLB-1:0] coef
   );
      logic [63:0] step;
      if (goal >= {32'd0, cur}) begin
         step = ((goal - {32'd0, cur}) * coef) >> ssbb_pkg::GLIDE_FRAC;
         return cur + step[SMB-1:0];
      end
      step = (({32'd0, cur} - goal) * coef) >> ssbb_pkg::GLIDE_FRAC;
      return cur - step[SMB-1:0];
   endfunction

   function automatic logic signed [AB-1:0] blend_toward(
      input logic signed [AB-1:0] acc,
      input logic signed [SB-1:0] held,
      input logic [SMB-1:0]       decay
   );
      logic signed [63:0] acc_w;
      logic signed [63:0] diff;
      logic signed [63:0] step_s;
      logic signed [63:0] acc_next;
      logic [63:0]        mag;
      logic [63:0]        step;
      acc_w = acc;
      diff = (64'(held) <<< ssbb_pkg::ACC_FRAC) - acc_w;
      mag = (diff < 0) ? -diff : diff;
      step = (mag * decay) >> ssbb_pkg::DECAY_FRAC;
      step_s = step;
      acc_next = (diff < 0) ? acc_w - step_s : acc_w + step_s;
      return acc_next[AB-1:0];
   endfunction

   function automatic logic signed [SB-1:0] scale_gain(
      input logic signed [AB-1:0] acc,
      input logic [GNB-1:0]       gain
   );
      logic signed [63:0] acc_w;
      logic signed [63:0] gain_w;
      logic signed [63:0] prod;
      logic signed [63:0] quot;
      logic [63:0]        mag;
      acc_w = acc;
      gain_w = {47'd0, gain};
      prod = acc_w * gain_w;
      mag = (prod < 0) ? -prod : prod;
      quot = mag >> (ssbb_pkg::GAIN_FRAC + ssbb_pkg::ACC_FRAC);
      if (prod < 0) quot = -quot;
      if (quot > SAT_HI) quot = SAT_HI;
      if (quot < SAT_LO) quot = SAT_LO;
      return quot[SB-1:0];
   endfunction

   function automatic void clear_blur_state();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         held_left[i] = '0;
         held_right[i] = '0;
         sum_left[i] = '0;
         sum_right[i] = '0;
      end
      slot_pos = '0;
      glided_len = '0;
      glided_decay = '0;
      cfg_length = ssbb_pkg::TARGET_LENGTH_RESET;
      cfg_decay = ssbb_pkg::DECAY_TARGET_RESET;
      cfg_glide = ssbb_pkg::GLIDE_COEF_RESET;
      cfg_gain = ssbb_pkg::VOLUME_GAIN_RESET;
      cfg_freeze = 1'b0;
   endfunction

   // one accepted pair: glide, write, blend, scale, advance
   function automatic void predict_pair(
      input logic signed [SB-1:0] left,
      input logic signed [SB-1:0] right
   );
      logic [DB-1:0]    decay_goal;
      logic [LB-1:0]    slot;
      logic [31:0]      len;
      logic [31:0]      lim;
      blurred_pair_type want;
      decay_goal = (cfg_decay > ssbb_pkg::DECAY_ONE) ? ssbb_pkg::DECAY_ONE : cfg_decay;
      slot = slot_pos;
      glided_len = glide_toward(glided_len, {32'd0, cfg_length, 16'd0}, cfg_glide);
      glided_decay = glide_toward(glided_decay, {32'd0, decay_goal, 16'd0}, cfg_glide);
      if (!cfg_freeze) begin
         held_left[slot] = left;
         held_right[slot] = right;
      end
      sum_left[slot] = blend_toward(sum_left[slot], held_left[slot], glided_decay);
      sum_right[slot] = blend_toward(sum_right[slot], held_right[slot], glided_decay);
      want.left_out = scale_gain(sum_left[slot], cfg_gain);
      want.right_out = scale_gain(sum_right[slot], cfg_gain);
      expected_pairs.push_back(want);
      len = glided_len >> 16;
      lim = (len < STORE_DEPTH) ? len : STORE_DEPTH;
      slot_pos = ({16'd0, slot} + 32'd1 >= lim) ? '0 : slot + 16'd1;
   endfunction

   task automatic write_reg(input logic [CIB-1:0] idx,
                            input logic [CDB-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         ssbb_pkg::CSR_TARGET_LENGTH: cfg_length = data[LB-1:0];
         ssbb_pkg::CSR_DECAY_TARGET: cfg_decay = data[DB-1:0];
         ssbb_pkg::CSR_GLIDE_COEF: cfg_glide = data[GLB-1:0];
         ssbb_pkg::CSR_VOLUME_GAIN: cfg_gain = data[GNB-1:0];
         ssbb_pkg::CSR_FREEZE: cfg_freeze = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_all_regs(input logic [LB-1:0] len, input logic [DB-1:0] dec,
                               input logic [GLB-1:0] gl, input logic [GNB-1:0] gain,
                               input logic frz);
      // unused upper data bits are filled at random, the block must drop them
      write_reg(ssbb_pkg::CSR_TARGET_LENGTH, {1'($urandom), len});
      write_reg(ssbb_pkg::CSR_DECAY_TARGET, {1'($urandom), dec});
      write_reg(ssbb_pkg::CSR_GLIDE_COEF, {8'($urandom), gl});
      write_reg(ssbb_pkg::CSR_VOLUME_GAIN, gain);
      write_reg(ssbb_pkg::CSR_FREEZE, {16'($urandom), frz});
   endtask

   // called at a falling edge; returns at a falling edge after the transaction
   task automatic send_pair(input logic signed [SB-1:0] left,
                            input logic signed [SB-1:0] right);
      req_left_in <= left;
      req_right_in <= right;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pair(left, right);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (tx_gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, tx_gap_max)) @(negedge clock);
         end
      end
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [SB-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SB'($signed($urandom_range(0, 511)) - 256);
         default: return SB'($urandom);
      endcase
   endfunction

   task automatic send_random_pairs(input int count);
      for (int i = 0; i < count; i++) send_pair(random_sample(), random_sample());
   endtask

   task automatic test_extreme_samples();
      tx_gap_max = 0;
      rx_stall_pct = 0;
      send_pair('0, '0);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair(SB'(-1), SB'(1));
      send_pair(SB'(1), SB'(-1));
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);
      send_pair(24'sh555555, 24'shAAAAAA);
      finish_phase();
   endtask

   task automatic test_register_extremes();
      // decay above one, top gain and top glide, length of one
      set_all_regs(16'd1, 16'hFFFF, 9'h1FF, 17'h1FFFF, 1'b0);
      for (int i = ssbb_pkg::CSR_FREEZE + 1; i < (1 << CIB); i++)
         write_reg(CIB'(i), CDB'($urandom));
      tx_gap_max = 3;
      rx_stall_pct = 30;
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);
      send_pair(24'sh7FF000, -24'sh7FF000);
      finish_phase();
      // zero length, zero glide, zero gain
      set_all_regs(16'd0, ssbb_pkg::DECAY_ONE, 9'd0, 17'd0, 1'b0);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SB'(-1), SB'(1));
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      finish_phase();
      // longest length, nominal top glide, gain of four
      set_all_regs(16'hFFFF, ssbb_pkg::DECAY_ONE, 9'd328, 17'd65536, 1'b0);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair('0, SB'(-1));
      finish_phase();
   endtask

   task automatic test_freeze();
      set_all_regs(16'd8, ssbb_pkg::DECAY_ONE, 9'h1FF, 17'd16384, 1'b0);
      tx_gap_max = 4;
      rx_stall_pct = 20;
      send_random_pairs(40);
      finish_phase();
      // held store stays, accumulators keep moving toward it
      write_reg(ssbb_pkg::CSR_FREEZE, {16'($urandom), 1'b1});
      send_random_pairs(50);
      finish_phase();
      write_reg(ssbb_pkg::CSR_FREEZE, {16'($urandom), 1'b0});
      send_random_pairs(10);
      finish_phase();
   endtask

   task automatic test_output_stall();
      set_all_regs(16'd20, 16'd20000, 9'd300, 17'd20000, 1'b0);
      tx_gap_max = 0;
      rx_stall_pct = 0;
      // receiver holds off long enough for the block to fill and stall its input
      rx_hold = 300;
      send_random_pairs(40);
      finish_phase();
   endtask

   task automatic test_random_settings();
      logic [LB-1:0]  len;
      logic [DB-1:0]  dec;
      logic [GLB-1:0] gl;
      logic [GNB-1:0] gain;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 6))
            0: len = 16'($urandom_range(0, 1));
            1: len = 16'hFFFF;
            2, 3: len = 16'($urandom_range(2, 48));
            4: len = 16'($urandom_range(49, 600));
            default: len = 16'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: gl = '0;
            1: gl = 9'h1FF;
            2: gl = 9'd328;
            default: gl = 9'($urandom_range(0, 511));
         endcase
         case ($urandom_range(0, 4))
            0: dec = '0;
            1: dec = ssbb_pkg::DECAY_ONE;
            2: dec = 16'($urandom_range(32769, 65535));
            default: dec = 16'($urandom_range(0, 32768));
         endcase
         case ($urandom_range(0, 4))
            0: gain = '0;
            1: gain = 17'h1FFFF;
            2: gain = 17'd65536;
            default: gain = 17'($urandom_range(0, 65536));
         endcase
         set_all_regs(len, dec, gl, gain, $urandom_range(0, 4) == 0);
         if (phase % 3 == 0) begin
            tx_gap_max = 0;
            rx_stall_pct = 0;
         end else begin
            tx_gap_max = $urandom_range(1, 10);
            rx_stall_pct = $urandom_range(5, 60);
         end
         send_random_pairs(125);
         finish_phase();
      end
   endtask

   // receiver: long hold-off, short stall runs, or ready
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_ready <= 1'b0;
         rx_hold--;
      end else if (rx_run > 0) begin
         rsp_ready <= 1'b0;
         rx_run--;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
         rsp_ready <= 1'b0;
         rx_run = $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      blurred_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $error("result transaction with nothing expected: left %0d right %0d",
                      rsp_left_out, rsp_right_out);
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_left_out !== want.left_out) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $error("left_out mismatch: expected %0d, actual %0d",
                         want.left_out, rsp_left_out);
            end
            if (rsp_right_out !== want.right_out) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $error("right_out mismatch: expected %0d, actual %0d",
                         want.right_out, rsp_right_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_stereo_slot_blur_buffer failed");
         $finish;
      end
   end

   initial begin
      clear_blur_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extreme_samples();
      test_register_extremes();
      test_freeze();
      test_output_stall();
      test_random_settings();
      if (fail_count == 0) begin
         $display("tb_stereo_slot_blur_buffer passed");
      end else begin
         $display("tb_stereo_slot_blur_buffer failed");
      end
      $finish;
   end

endmodule
